// ===== hdl/gdad_pkg.sv =====
package gdad_pkg;

	// Field widths
	localparam int YEAR_W  = 20;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int COUNT_W = 15;

	// Year-mod-400 unit: floor(year / 400) = floor(floor(year / 16) / 25),
	// the division by 25 done by reciprocal multiplication, then one subtract
	localparam int Y16_W    = YEAR_W - 4;
	localparam int RECIP_W  = 17;
	localparam int PROD_W   = Y16_W + RECIP_W;
	localparam int RECIP_SH = 21;
	localparam int QUO_W    = PROD_W - RECIP_SH;
	localparam logic [RECIP_W-1:0] RECIP_25 = 17'd83887;
	localparam int REM_W   = 9;
	localparam logic [YEAR_W-1:0]  YEAR_CYCLE    = 20'd400;
	localparam logic [REM_W-1:0]   REM_LAST      = 9'd399;
	localparam logic [REM_W-1:0]   REM_C100      = 9'd100;
	localparam logic [REM_W-1:0]   REM_C200      = 9'd200;
	localparam logic [REM_W-1:0]   REM_C300      = 9'd300;

	// Calendar constants
	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
	localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
	localparam logic [DAY_W-1:0]   FEB_LEAP  = 5'd29;
	localparam logic [DAY_W-1:0]   FEB_PLAIN = 5'd28;
	localparam logic [DAY_W-1:0]   MONTH_LEN [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	// Microcode step addresses
	localparam int STEP_W = 2;
	typedef logic [STEP_W-1:0] step_t;
	localparam step_t STEP_IDLE = 2'd0;
	localparam step_t STEP_MOD  = 2'd1;
	localparam step_t STEP_DAY  = 2'd2;
	localparam step_t STEP_DONE = 2'd3;

	// Jump condition of a step; on false the step repeats
	typedef enum logic [1:0] {
		COND_IN_BEAT,
		COND_MOD_LAST,
		COND_CNT_ZERO,
		COND_OUT_FREE
	} cond_t;

	// How the step's actions depend on its condition
	typedef enum logic [1:0] {
		GATE_NONE,
		GATE_TRUE,
		GATE_FALSE
	} gate_t;

	typedef struct packed {
		cond_t cond;
		gate_t gate;
		step_t target;
		logic  load;
		logic  mod_step;
		logic  day_step;
		logic  emit;
	} uword_t;

	// Sequencer to datapath / output stage
	typedef struct packed {
		logic take;
		logic load;
		logic mod_step;
		logic day_step;
		logic emit;
	} ctrl_t;

	// Datapath flags back to the sequencer
	typedef struct packed {
		logic mod_last;
		logic cnt_zero;
	} dp_stat_t;

	// Everything the sequencer branches on
	typedef struct packed {
		logic in_beat;
		logic mod_last;
		logic cnt_zero;
		logic out_free;
	} status_t;

	// Control store
	function automatic uword_t ucode_rom(input step_t pc);
		uword_t w;
		w = '{cond: COND_IN_BEAT, gate: GATE_TRUE, target: STEP_MOD,
			load: 1'b1, mod_step: 1'b0, day_step: 1'b0, emit: 1'b0};
		case (pc)
			STEP_IDLE: w = '{cond: COND_IN_BEAT, gate: GATE_TRUE, target: STEP_MOD,
				load: 1'b1, mod_step: 1'b0, day_step: 1'b0, emit: 1'b0};
			STEP_MOD:  w = '{cond: COND_MOD_LAST, gate: GATE_NONE, target: STEP_DAY,
				load: 1'b0, mod_step: 1'b1, day_step: 1'b0, emit: 1'b0};
			STEP_DAY:  w = '{cond: COND_CNT_ZERO, gate: GATE_FALSE, target: STEP_DONE,
				load: 1'b0, mod_step: 1'b0, day_step: 1'b1, emit: 1'b0};
			STEP_DONE: w = '{cond: COND_OUT_FREE, gate: GATE_TRUE, target: STEP_IDLE,
				load: 1'b0, mod_step: 1'b0, day_step: 1'b0, emit: 1'b1};
			default:   w = '{cond: COND_IN_BEAT, gate: GATE_TRUE, target: STEP_MOD,
				load: 1'b1, mod_step: 1'b0, day_step: 1'b0, emit: 1'b0};
		endcase
		return w;
	endfunction

	// Days in a month; months outside 1..12 have none
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		if (m < MONTH_JAN || m > MONTH_DEC) begin
			len = '0;
		end else if (m == MONTH_FEB) begin
			len = leap ? FEB_LEAP : FEB_PLAIN;
		end else begin
			len = MONTH_LEN[m - MONTH_JAN];
		end
		return len;
	endfunction

endpackage

// ===== hdl/gdad_seq.sv =====
module gdad_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  gdad_pkg::status_t stat,
	output gdad_pkg::ctrl_t   ctrl
);
	import gdad_pkg::*;

	step_t  pc_q;
	uword_t uw;
	logic   cond_ok;
	logic   act;

	// Fetch and condition select
	always_comb begin
		uw = ucode_rom(pc_q);
		case (uw.cond)
			COND_IN_BEAT:  cond_ok = stat.in_beat;
			COND_MOD_LAST: cond_ok = stat.mod_last;
			COND_CNT_ZERO: cond_ok = stat.cnt_zero;
			COND_OUT_FREE: cond_ok = stat.out_free;
			default:       cond_ok = 1'b0;
		endcase
		case (uw.gate)
			GATE_NONE:  act = 1'b1;
			GATE_TRUE:  act = cond_ok;
			GATE_FALSE: act = ~cond_ok;
			default:    act = 1'b0;
		endcase
		ctrl.take     = uw.load;
		ctrl.load     = uw.load & act;
		ctrl.mod_step = uw.mod_step & act;
		ctrl.day_step = uw.day_step & act;
		ctrl.emit     = uw.emit & act;
	end

	// Step counter: jump on true, repeat on false
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_IDLE;
		end else if (cond_ok) begin
			pc_q <= uw.target;
		end
	end

endmodule

// ===== hdl/gdad_dpath.sv =====
module gdad_dpath (
	input  logic                               clk,
	input  gdad_pkg::ctrl_t                    ctrl,
	input  logic [gdad_pkg::YEAR_W-1:0]        start_year,
	input  logic [gdad_pkg::MONTH_W-1:0]       start_month,
	input  logic [gdad_pkg::DAY_W-1:0]         start_day,
	input  logic [gdad_pkg::COUNT_W-1:0]       days_to_add,
	output logic [gdad_pkg::YEAR_W-1:0]        year,
	output logic [gdad_pkg::MONTH_W-1:0]       month,
	output logic [gdad_pkg::DAY_W-1:0]         day,
	output gdad_pkg::dp_stat_t                 stat
);
	import gdad_pkg::*;

	logic [YEAR_W-1:0]  year_q;
	logic [MONTH_W-1:0] mon_q;
	logic [DAY_W-1:0]   day_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [QUO_W-1:0]   quo_q;
	logic [REM_W-1:0]   rem_q;
	logic               ph_q;

	logic [PROD_W-1:0]  prod;
	logic [YEAR_W-1:0]  rem_full;
	logic [REM_W-1:0]   r400;
	logic [REM_W-1:0]   r400_inc;
	logic               leap;
	logic [DAY_W-1:0]   mlen;
	logic               roll;

	// Year mod 400 (quotient, then remainder) and calendar decode
	always_comb begin
		prod     = {{RECIP_W{1'b0}}, year_q[YEAR_W-1 -: Y16_W]} *
			{{Y16_W{1'b0}}, RECIP_25};
		rem_full = year_q - ({{(YEAR_W-QUO_W){1'b0}}, quo_q} * YEAR_CYCLE);
		r400     = rem_q;
		// wrap of the 20-bit year lands on year 0
		r400_inc = (r400 == REM_LAST || year_q == '1) ? '0 : r400 + 1'b1;
		leap     = (r400[1:0] == 2'b00) && (r400 != REM_C100) &&
			(r400 != REM_C200) && (r400 != REM_C300);
		mlen     = month_len(mon_q, leap);
		roll     = (day_q >= mlen);
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			year_q <= start_year;
			mon_q  <= start_month;
			day_q  <= start_day;
			cnt_q  <= days_to_add;
			ph_q   <= 1'b0;
		end else if (ctrl.mod_step) begin
			// first step: quotient; second step: remainder
			if (!ph_q) begin
				quo_q <= prod[PROD_W-1 -: QUO_W];
			end else begin
				rem_q <= rem_full[REM_W-1:0];
			end
			ph_q <= ~ph_q;
		end else if (ctrl.day_step) begin
			cnt_q <= cnt_q - 1'b1;
			if (roll) begin
				day_q <= DAY_FIRST;
				if (mon_q >= MONTH_DEC) begin
					mon_q  <= MONTH_JAN;
					year_q <= year_q + 1'b1;
					rem_q  <= r400_inc;
				end else begin
					mon_q <= mon_q + 1'b1;
				end
			end else begin
				day_q <= day_q + 1'b1;
			end
		end
	end

	assign year          = year_q;
	assign month         = mon_q;
	assign day           = day_q;
	assign stat.mod_last = ph_q;
	assign stat.cnt_zero = (cnt_q == '0);

endmodule

// ===== hdl/gregorian_date_add_days_unit.sv =====
// Channel | Signals                                              | Direction
// --------+------------------------------------------------------+----------
// in      | in_valid, in_stall, start_year/month/day, days_to_add | beat in
// out     | out_valid, out_stall, end_year, end_month, end_day    | beat out
//
// An item passes through one accept, two steps of the year-mod-400
// reduction (reciprocal multiply, then subtract), one microcode step per day
// advanced, one exit test and one hand-off to the output register.
// Reset clears the step counter and the output valid; payload is not reset.
// A stalled result sits in the output register while the next item is taken;
// the next result then waits in the hand-off step until the register frees.
module gregorian_date_add_days_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [gdad_pkg::YEAR_W-1:0]   start_year,
	input  logic [gdad_pkg::MONTH_W-1:0]  start_month,
	input  logic [gdad_pkg::DAY_W-1:0]    start_day,
	input  logic [gdad_pkg::COUNT_W-1:0]  days_to_add,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [gdad_pkg::YEAR_W-1:0]   end_year,
	output logic [gdad_pkg::MONTH_W-1:0]  end_month,
	output logic [gdad_pkg::DAY_W-1:0]    end_day
);
	import gdad_pkg::*;

	ctrl_t    ctrl;
	status_t  stat;
	dp_stat_t dp_stat;

	logic [YEAR_W-1:0]  dp_year;
	logic [MONTH_W-1:0] dp_month;
	logic [DAY_W-1:0]   dp_day;

	logic               out_valid_q;
	logic [YEAR_W-1:0]  end_year_q;
	logic [MONTH_W-1:0] end_month_q;
	logic [DAY_W-1:0]   end_day_q;

	// Branch inputs
	assign in_stall      = ~ctrl.take;
	assign stat.in_beat  = in_valid & ctrl.take;
	assign stat.mod_last = dp_stat.mod_last;
	assign stat.cnt_zero = dp_stat.cnt_zero;
	assign stat.out_free = ~out_valid_q | ~out_stall;

	gdad_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	gdad_dpath u_dpath (
		.clk         (clk),
		.ctrl        (ctrl),
		.start_year  (start_year),
		.start_month (start_month),
		.start_day   (start_day),
		.days_to_add (days_to_add),
		.year        (dp_year),
		.month       (dp_month),
		.day         (dp_day),
		.stat        (dp_stat)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			end_year_q  <= dp_year;
			end_month_q <= dp_month;
			end_day_q   <= dp_day;
		end
	end

	assign out_valid = out_valid_q;
	assign end_year  = end_year_q;
	assign end_month = end_month_q;
	assign end_day   = end_day_q;

`ifndef ASSERT_OFF
	// A result never overwrites one that is still stalled
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit |-> (!out_valid_q || !out_stall))
		else $error("result loaded over a stalled beat");

	// The sequencer leaves idle right after taking a beat
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken twice in a row");

	// Loading and emitting never share a step
	a_load_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.load && ctrl.emit))
		else $error("load and emit in one step");
`endif

endmodule

// ===== tb/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import gdad_pkg::*;

	localparam int CLK_PERIOD     = 8;
	localparam int RESET_CYCLES   = 8;
	localparam int CYCLE_LIMIT    = 2000000;
	localparam int TAIL_CYCLES    = 40;
	localparam int HOLD_CYCLES    = 2000;
	localparam int PHASES         = 4;
	localparam int ITEMS_PER_PHASE = 19;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
	} cal_date_t;

	// One input beat plus an optional hand-typed answer
	typedef struct packed {
		cal_date_t          from;
		logic [COUNT_W-1:0] span;
		logic               pin;
		cal_date_t          want;
	} stim_row_t;

	typedef struct packed {
		logic      pin;
		cal_date_t want;
	} known_answer_t;

	// Month lengths, January first
	localparam logic [DAY_W-1:0] DAYS_PER_MONTH [0:11] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [YEAR_W-1:0]  start_year = '0;
	logic [MONTH_W-1:0] start_month = '0;
	logic [DAY_W-1:0]   start_day = '0;
	logic [COUNT_W-1:0] days_to_add = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [YEAR_W-1:0]  end_year;
	logic [MONTH_W-1:0] end_month;
	logic [DAY_W-1:0]   end_day;

	known_answer_t known_answer_q[$];
	cal_date_t     due_dates_q[$];
	stim_row_t     dir_rows[$];

	int fail_count = 0;
	int sent_count = 0;
	int done_count = 0;
	int cycle_count = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	logic hold_req = 1'b0;
	logic hold_used = 1'b0;
	int hold_left = 0;

	gregorian_date_add_days_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.start_year  (start_year),
		.start_month (start_month),
		.start_day   (start_day),
		.days_to_add (days_to_add),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.end_year    (end_year),
		.end_month   (end_month),
		.end_day     (end_day)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Calendar rules
	function automatic logic is_leap_year(input logic [YEAR_W-1:0] y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
		input logic [YEAR_W-1:0] y);
		logic [DAY_W-1:0] len;
		if (m < MONTH_JAN || m > MONTH_DEC) begin
			len = '0;
		end else if (m == MONTH_FEB) begin
			len = is_leap_year(y) ? FEB_LEAP : FEB_PLAIN;
		end else begin
			len = DAYS_PER_MONTH[m - MONTH_JAN];
		end
		return len;
	endfunction

	// Walk the date forward one day per step; the year wraps at 20 bits
	function automatic cal_date_t advance_date(input cal_date_t from,
		input logic [COUNT_W-1:0] span);
		cal_date_t d;
		int i;
		d = from;
		for (i = 0; i < span; i++) begin
			if (d.day >= month_days(d.month, d.year)) begin
				d.day = DAY_FIRST;
				if (d.month >= MONTH_DEC) begin
					d.month = MONTH_JAN;
					d.year = d.year + 1'b1;
				end else begin
					d.month = d.month + 1'b1;
				end
			end else begin
				d.day = d.day + 1'b1;
			end
		end
		return d;
	endfunction

	function automatic stim_row_t mk_row(input int y, input int m, input int d,
		input int n, input bit pin, input int ey, input int em, input int ed);
		stim_row_t r;
		r.from = {y[YEAR_W-1:0], m[MONTH_W-1:0], d[DAY_W-1:0]};
		r.span = n[COUNT_W-1:0];
		r.pin  = pin;
		r.want = {ey[YEAR_W-1:0], em[MONTH_W-1:0], ed[DAY_W-1:0]};
		return r;
	endfunction

	// Mostly valid dates, often near month ends, some junk dates; spans mostly short
	function automatic stim_row_t random_row(input int k);
		stim_row_t r;
		int len;
		r = '0;
		case ($urandom_range(0, 9))
			0, 1:    r.from.year = YEAR_W'($urandom_range(0, 10000) * 100);
			2:       r.from.year = YEAR_W'($urandom_range(0, 20'hFFFFF));
			default: r.from.year = YEAR_W'($urandom_range(0, 1000000));
		endcase
		if ($urandom_range(0, 99) < 85) begin
			r.from.month = MONTH_W'($urandom_range(MONTH_JAN, MONTH_DEC));
			len = month_days(r.from.month, r.from.year);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: r.from.day = DAY_W'(len);
				4:          r.from.day = DAY_W'(len - 1);
				default:    r.from.day = DAY_W'($urandom_range(1, len));
			endcase
		end else begin
			r.from.month = MONTH_W'($urandom_range(0, 15));
			r.from.day = DAY_W'($urandom_range(0, 31));
		end
		if (k % 25 == 12) begin
			r.span = COUNT_W'($urandom_range(0, 32767));
		end else if (k % 5 == 3) begin
			r.span = COUNT_W'($urandom_range(0, 2047));
		end else if ($urandom_range(0, 1) == 0) begin
			r.span = COUNT_W'($urandom_range(0, 3));
		end else begin
			r.span = COUNT_W'($urandom_range(0, 400));
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at cycle %0d: %s got %0d expected %0d",
			cycle_count, what, got, want);
		fail_count++;
	endtask

	// Offer one beat, with a random gap ahead of it; valid stays high after
	task automatic offer_beat(input stim_row_t r);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
		end
		known_answer_q.push_back({r.pin, r.want});
		in_valid    <= 1'b1;
		start_year  <= r.from.year;
		start_month <= r.from.month;
		start_day   <= r.from.day;
		days_to_add <= r.span;
		do @(posedge clk); while (in_stall);
		sent_count++;
	endtask

	// Sender pauses until every result of the beats so far has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (done_count != sent_count) @(posedge clk);
	endtask

	// Stimulus
	initial begin
		int p;
		int j;
		dir_rows.push_back(mk_row(2024, 2, 29, 0, 1, 2024, 2, 29));
		dir_rows.push_back(mk_row(20'hFFFFF, 15, 31, 0, 1, 20'hFFFFF, 15, 31));
		dir_rows.push_back(mk_row(0, 0, 0, 0, 1, 0, 0, 0));
		dir_rows.push_back(mk_row(1999, 12, 31, 1, 1, 2000, 1, 1));
		dir_rows.push_back(mk_row(2000, 2, 28, 1, 1, 2000, 2, 29));
		dir_rows.push_back(mk_row(1900, 2, 28, 1, 1, 1900, 3, 1));
		dir_rows.push_back(mk_row(2024, 2, 29, 1, 1, 2024, 3, 1));
		dir_rows.push_back(mk_row(2023, 2, 28, 1, 1, 2023, 3, 1));
		dir_rows.push_back(mk_row(2100, 2, 28, 1, 1, 2100, 3, 1));
		dir_rows.push_back(mk_row(0, 2, 28, 1, 1, 0, 2, 29));
		dir_rows.push_back(mk_row(1000000, 2, 28, 1, 1, 1000000, 2, 29));
		// months outside 1..12 have no days
		dir_rows.push_back(mk_row(2023, 0, 5, 1, 1, 2023, 1, 1));
		dir_rows.push_back(mk_row(2023, 13, 1, 1, 1, 2024, 1, 1));
		dir_rows.push_back(mk_row(2023, 15, 31, 1, 1, 2024, 1, 1));
		// day zero and day past the month's end
		dir_rows.push_back(mk_row(2023, 4, 0, 1, 1, 2023, 4, 1));
		dir_rows.push_back(mk_row(2023, 4, 31, 1, 1, 2023, 5, 1));
		dir_rows.push_back(mk_row(2023, 2, 31, 1, 1, 2023, 3, 1));
		// year wraps out of 20 bits
		dir_rows.push_back(mk_row(20'hFFFFF, 12, 31, 1, 1, 0, 1, 1));
		dir_rows.push_back(mk_row(2023, 1, 1, 365, 1, 2024, 1, 1));
		dir_rows.push_back(mk_row(2024, 1, 1, 366, 1, 2025, 1, 1));
		dir_rows.push_back(mk_row(2023, 11, 30, 1, 1, 2023, 12, 1));
		dir_rows.push_back(mk_row(0, 1, 1, 32767, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(1000000, 12, 31, 32767, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(20'hFFFF0, 6, 15, 32767, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(2023, 0, 0, 40, 0, 0, 0, 0));

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) offer_beat(dir_rows[i]);
		drain_results();

		// Random phases with different idle and stall mixes
		for (p = 0; p < PHASES; p++) begin
			case (p)
				0: begin idle_pct = 0;  stall_pct <= 0;  hold_req <= 1'b1; end
				1: begin idle_pct = 74; stall_pct <= 0;  end
				2: begin idle_pct = 0;  stall_pct <= 74; end
				default: begin idle_pct = 32; stall_pct <= 32; end
			endcase
			for (j = 0; j < ITEMS_PER_PHASE; j++)
				offer_beat(random_row(p * ITEMS_PER_PHASE + j));
			drain_results();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (due_dates_q.size() != 0)
			report_mismatch("results never produced", due_dates_q.size(), 0);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off to back the block up
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_used) begin
			out_stall <= 1'b1;
			hold_used <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end else begin
			out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Monitor: predict on input beats, check output beats in order
	always @(posedge clk) begin : watch
		known_answer_t ka;
		cal_date_t     want;
		cal_date_t     got;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				ka = known_answer_q.pop_front();
				if (ka.pin)
					due_dates_q.push_back(ka.want);
				else
					due_dates_q.push_back(advance_date(
						{start_year, start_month, start_day}, days_to_add));
			end
			if (out_valid && !out_stall) begin
				got = {end_year, end_month, end_day};
				if (due_dates_q.size() == 0) begin
					report_mismatch("result with nothing pending", got.year, 0);
				end else begin
					want = due_dates_q.pop_front();
					if (got.year !== want.year)
						report_mismatch("end_year", got.year, want.year);
					if (got.month !== want.month)
						report_mismatch("end_month", got.month, want.month);
					if (got.day !== want.day)
						report_mismatch("end_day", got.day, want.day);
				end
				done_count++;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("== FAIL ==");
			$finish;
		end
	end

endmodule
